// ----- sv/thumb2_store_decode_assert.svh -----
// assertion macros for the store decoder
`ifndef THUMB2_STORE_DECODE_ASSERT_SVH
`define THUMB2_STORE_DECODE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define T2SD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("store decode check failed");

// next-cycle implication, checked outside reset
`define T2SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("store decode check failed");

`endif

// ----- sv/t2sd_pkg.sv -----
// types, match masks and helpers for the thumb-2 store decoder
package t2sd_pkg;

  typedef enum logic [3:0] {
    ENC_NONE        = 4'd0,
    ENC_STR_IMM_T3  = 4'd1,
    ENC_STR_IMM_T4  = 4'd2,
    ENC_STR_REG     = 4'd3,
    ENC_STRB_IMM_T2 = 4'd4,
    ENC_STRB_IMM_T3 = 4'd5,
    ENC_STRB_REG    = 4'd6,
    ENC_STRD        = 4'd7,
    ENC_STRH_IMM_T2 = 4'd8,
    ENC_STRH_IMM_T3 = 4'd9,
    ENC_STRH_REG    = 4'd10
  } enc_t;

  typedef struct packed {
    enc_t        encoding;
    logic [3:0]  source_reg;
    logic [3:0]  second_source_reg;
    logic [3:0]  base_reg;
    logic [3:0]  offset_reg;
    logic [1:0]  shift_amount;
    logic [11:0] offset;
    logic        pre_index;
    logic        add_offset;
    logic        write_back;
    logic        unpredictable;
  } result_t;

  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_PC = 4'd15;

  // must-be-one / must-be-zero masks per encoding
  localparam logic [31:0] STR_IMM_T3_ONE  = 32'hf8c00000;
  localparam logic [31:0] STR_IMM_T3_ZERO = 32'h07300000;
  localparam logic [31:0] STR_IMM_T4_ONE  = 32'hf8400800;
  localparam logic [31:0] STR_IMM_T4_ZERO = 32'h07b00000;
  localparam logic [31:0] STR_REG_ONE     = 32'hf8400000;
  localparam logic [31:0] STR_REG_ZERO    = 32'h07b00fc0;
  localparam logic [31:0] STRB_IMM_T2_ONE  = 32'hf8800000;
  localparam logic [31:0] STRB_IMM_T2_ZERO = 32'h07700000;
  localparam logic [31:0] STRB_IMM_T3_ONE  = 32'hf8000800;
  localparam logic [31:0] STRB_IMM_T3_ZERO = 32'h07f00000;
  localparam logic [31:0] STRB_REG_ONE     = 32'hf8000000;
  localparam logic [31:0] STRB_REG_ZERO    = 32'h07f00fc0;
  localparam logic [31:0] STRD_ONE         = 32'he8400000;
  localparam logic [31:0] STRD_ZERO        = 32'h16100000;
  localparam logic [31:0] STRH_IMM_T2_ONE  = 32'hf8a00000;
  localparam logic [31:0] STRH_IMM_T2_ZERO = 32'h07500000;
  localparam logic [31:0] STRH_IMM_T3_ONE  = 32'hf8200800;
  localparam logic [31:0] STRH_IMM_T3_ZERO = 32'h07d00000;
  localparam logic [31:0] STRH_REG_ONE     = 32'hf8200000;
  localparam logic [31:0] STRH_REG_ZERO    = 32'h07d00fc0;

  // exclusion patterns
  localparam logic [31:0] RN_PC_ONE   = 32'h000f0000;
  localparam logic [31:0] UNPRIV_ONE  = 32'h00000600;
  localparam logic [31:0] UNPRIV_ZERO = 32'h00000100;
  localparam logic [31:0] NOIDX_ZERO  = 32'h00000500;
  localparam logic [31:0] PUSH_ONE    = 32'h000d0500;
  localparam logic [31:0] PUSH_ZERO   = 32'h00020200;

  function automatic logic bits_match(input logic [31:0] w, input logic [31:0] ones,
                                      input logic [31:0] zeros);
    return ((w & ones) == ones) && ((w & zeros) == 32'd0);
  endfunction

  function automatic logic bad_reg(input logic [3:0] r);
    return (r == REG_SP) || (r == REG_PC);
  endfunction

endpackage

// ----- sv/t2sd_ifs.sv -----
// valid/ready channels for instruction words and decode results
interface t2sd_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

interface t2sd_result_if import t2sd_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/t2sd_in_stage.sv -----
// input register holding one instruction word
module t2sd_in_stage (
  input  logic         clk,
  input  logic         rst_n,
  t2sd_instr_if.sink   in_ch,
  input  logic         s1_take,
  output logic         s1_valid,
  output logic [31:0]  s1_instr
);

  logic        valid_r, valid_nxt;
  logic [31:0] instr_r;
  logic        accept;

  assign in_ch.ready = !valid_r || s1_take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (s1_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      instr_r <= in_ch.instruction;
    end
  end

  assign s1_valid = valid_r;
  assign s1_instr = instr_r;

endmodule

// ----- sv/t2sd_decode.sv -----
// combinational match and operand decode of one instruction word
module t2sd_decode import t2sd_pkg::*; (
  input  logic [31:0] instr,
  output result_t     res
);

  enc_t       enc;
  logic       rn_pc, unpriv, no_idx_wb, push_form;
  logic [3:0] rt, rn, rm;

  assign rt = instr[15:12];
  assign rn = instr[19:16];
  assign rm = instr[3:0];

  assign rn_pc     = bits_match(instr, RN_PC_ONE, 32'd0);
  assign unpriv    = bits_match(instr, UNPRIV_ONE, UNPRIV_ZERO);
  assign no_idx_wb = bits_match(instr, 32'd0, NOIDX_ZERO);
  assign push_form = bits_match(instr, PUSH_ONE, PUSH_ZERO);

  // priority order of the encodings matters where masks overlap
  always_comb begin
    enc = ENC_NONE;
    if (bits_match(instr, STR_IMM_T3_ONE, STR_IMM_T3_ZERO) && !rn_pc) begin
      enc = ENC_STR_IMM_T3;
    end else if (bits_match(instr, STR_IMM_T4_ONE, STR_IMM_T4_ZERO) && !unpriv &&
                 !push_form && !rn_pc && !no_idx_wb) begin
      enc = ENC_STR_IMM_T4;
    end else if (bits_match(instr, STR_REG_ONE, STR_REG_ZERO) && !rn_pc) begin
      enc = ENC_STR_REG;
    end else if (bits_match(instr, STRB_IMM_T2_ONE, STRB_IMM_T2_ZERO)) begin
      enc = ENC_STRB_IMM_T2;
    end else if (bits_match(instr, STRB_IMM_T3_ONE, STRB_IMM_T3_ZERO) && !unpriv &&
                 !rn_pc && !no_idx_wb) begin
      enc = ENC_STRB_IMM_T3;
    end else if (bits_match(instr, STRB_REG_ONE, STRB_REG_ZERO) && !rn_pc) begin
      enc = ENC_STRB_REG;
    end else if (bits_match(instr, STRD_ONE, STRD_ZERO)) begin
      enc = ENC_STRD;
    end else if (bits_match(instr, STRH_IMM_T2_ONE, STRH_IMM_T2_ZERO) && !rn_pc) begin
      enc = ENC_STRH_IMM_T2;
    end else if (bits_match(instr, STRH_IMM_T3_ONE, STRH_IMM_T3_ZERO) && !unpriv &&
                 !rn_pc && !no_idx_wb) begin
      enc = ENC_STRH_IMM_T3;
    end else if (bits_match(instr, STRH_REG_ONE, STRH_REG_ZERO) && !rn_pc) begin
      enc = ENC_STRH_REG;
    end
  end

  always_comb begin
    res                   = '0;
    res.encoding          = enc;
    res.source_reg        = rt;
    res.base_reg          = rn;
    res.pre_index         = 1'b1;
    res.add_offset        = 1'b1;
    case (enc)
      ENC_STR_IMM_T3, ENC_STRB_IMM_T2, ENC_STRH_IMM_T2: begin
        res.offset = instr[11:0];
        if (enc == ENC_STR_IMM_T3) begin
          res.unpredictable = (rt == REG_PC);
        end else if (enc == ENC_STRB_IMM_T2) begin
          res.unpredictable = (rn == REG_PC) || bad_reg(rt);
        end else begin
          res.unpredictable = bad_reg(rt);
        end
      end
      ENC_STR_IMM_T4, ENC_STRB_IMM_T3, ENC_STRH_IMM_T3: begin
        res.offset        = {4'd0, instr[7:0]};
        res.write_back    = instr[8];
        res.add_offset    = instr[9];
        res.pre_index     = instr[10];
        res.unpredictable = ((enc == ENC_STR_IMM_T4) ? (rt == REG_PC) : bad_reg(rt)) ||
                            (instr[8] && (rn == rt));
      end
      ENC_STR_REG, ENC_STRB_REG, ENC_STRH_REG: begin
        res.offset_reg    = rm;
        res.shift_amount  = instr[5:4];
        res.unpredictable = ((enc == ENC_STR_REG) ? (rt == REG_PC) : bad_reg(rt)) ||
                            bad_reg(rm);
      end
      ENC_STRD: begin
        res.second_source_reg = instr[11:8];
        res.offset            = {2'd0, instr[7:0], 2'd0};
        res.write_back        = instr[21];
        res.add_offset        = instr[23];
        res.pre_index         = instr[24];
        // no index and no writeback still decodes but is flagged
        res.unpredictable     = (!instr[24] && !instr[21]) ||
                                (instr[21] && ((rn == rt) || (rn == instr[11:8]))) ||
                                (rn == REG_PC) || bad_reg(rt) || bad_reg(instr[11:8]);
      end
      default: begin
        res.source_reg = 4'd0;
        res.base_reg   = 4'd0;
        res.pre_index  = 1'b0;
        res.add_offset = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/t2sd_out_stage.sv -----
// result register towards the receiver
module t2sd_out_stage import t2sd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s1_valid,
  input  result_t       res,
  output logic          s1_take,
  t2sd_result_if.source out_ch
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  // load whenever the register is empty or its transaction completes now
  assign s1_take = s1_valid && (!valid_r || out_ch.ready);

  always_comb begin
    valid_nxt = valid_r;
    if (s1_take) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      data_r <= res;
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.data  = data_r;

endmodule

// ----- sv/thumb2_store_decode.sv -----
// Thumb-2 store instruction decoder, top level
//
// in_ch carries one 32-bit instruction word per transaction, first halfword
// in bits 31:16. out_ch returns one decode result per instruction, in order:
// matched store encoding, register numbers, immediate offset, shift amount,
// P/U/W bits and an unpredictable flag. Words that match no store encoding
// give an all-zero result.
// An accepted word is held first in the input register, then the decode
// logic loads the result register, whose valid flag drives out_ch.valid.
// One instruction is taken every cycle while out_ch.ready stays high; the
// rate is set by the single decode pass between the two registers.
// When the receiver stalls the result register holds, the input register
// keeps one more word, and then in_ch.ready drops until a result leaves.
// A synchronous active-low reset empties both registers; no results are
// shown after reset until new words arrive.
`include "thumb2_store_decode_assert.svh"

module thumb2_store_decode import t2sd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  t2sd_instr_if.sink    in_ch,
  t2sd_result_if.source out_ch
);

  logic        s1_valid;
  logic        s1_take;
  logic [31:0] s1_instr;
  result_t     dec_res;
  logic        out_stall, in_accept, out_nomatch, out_no_idx_wb, out_strd_flagged;

  t2sd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_instr (s1_instr)
  );

  t2sd_decode u_decode (
    .instr (s1_instr),
    .res   (dec_res)
  );

  t2sd_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .res      (dec_res),
    .s1_take  (s1_take),
    .out_ch   (out_ch)
  );

  assign out_stall        = out_ch.valid && !out_ch.ready;
  assign in_accept        = in_ch.valid && in_ch.ready;
  assign out_nomatch      = out_ch.valid && (out_ch.data.encoding == ENC_NONE);
  assign out_no_idx_wb    = out_ch.valid && (out_ch.data.encoding != ENC_NONE) &&
                            !out_ch.data.pre_index && !out_ch.data.write_back;
  assign out_strd_flagged = (out_ch.data.encoding == ENC_STRD) && out_ch.data.unpredictable;

  // both registers full and receiver stalled: no room for another word
  `T2SD_ASSERT_NOW(a_full_blocks_input, clk, rst_n, s1_valid && out_stall, !in_ch.ready)
  // an accepted word always lands in the input register
  `T2SD_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_accept, s1_valid)
  // no-match results are all zero
  `T2SD_ASSERT_NOW(a_nomatch_zero, clk, rst_n, out_nomatch, out_ch.data == '0)
  // only the dual store decodes without index and writeback, and it is flagged
  `T2SD_ASSERT_NOW(a_strd_noidx, clk, rst_n, out_no_idx_wb, out_strd_flagged)

endmodule
